// ===== rtl/sfci_pkg.sv =====
// ----------------------------------------------------------------------------
// SPIR-V float-controls injector package
// Opcodes, status codes, the command word between front and back, and the
// tables of inserted words.
// ----------------------------------------------------------------------------
package sfci_pkg;

	localparam logic [15:0] OP_CAPABILITY     = 16'd17;
	localparam logic [15:0] OP_ENTRY_POINT    = 16'd15;
	localparam logic [15:0] OP_EXECUTION_MODE = 16'd16;

	localparam logic [2:0] HEADER_WORDS = 3'd5;
	localparam logic [2:0] COUNT_SAT    = 3'd6;

	localparam logic [1:0] STATUS_APPLIED   = 2'd0;
	localparam logic [1:0] STATUS_MALFORMED = 2'd1;
	localparam logic [1:0] STATUS_NO_POINT  = 2'd2;
	localparam logic [1:0] STATUS_SHORT     = 2'd3;

	localparam logic [3:0] CAP_WORDS  = 4'd11;
	localparam logic [3:0] MODE_WORDS = 4'd8;

	typedef enum logic [1:0] {
		INS_NONE,
		INS_CAPS,
		INS_MODES
	} ins_t;

	typedef struct packed {
		logic        pend_v;
		logic [31:0] pend_word;
		ins_t        ins;
		logic [31:0] ep_id;
		logic        word_v;
		logic [31:0] word;
		logic        last;
		logic [1:0]  status;
	} cmd_t;

	function automatic logic [31:0] cap_word(input logic [3:0] idx);
		logic [31:0] w;
		case (idx)
			4'd0:    w = 32'h0002_0011;
			4'd1:    w = 32'd4465;
			4'd2:    w = 32'h0002_0011;
			4'd3:    w = 32'd4466;
			4'd4:    w = 32'h0007_000A;
			4'd5:    w = 32'h5F56_5053;
			4'd6:    w = 32'h5F52_484B;
			4'd7:    w = 32'h616F_6C66;
			4'd8:    w = 32'h6F63_5F74;
			4'd9:    w = 32'h6F72_746E;
			4'd10:   w = 32'h0000_736C;
			default: w = 32'h0000_0000;
		endcase
		return w;
	endfunction

	function automatic logic [31:0] mode_word(input logic [2:0] idx, input logic [31:0] id);
		logic [31:0] w;
		case (idx[1:0])
			2'd0:    w = 32'h0004_0010;
			2'd1:    w = id;
			2'd2:    w = idx[2] ? 32'd4461 : 32'd4460;
			2'd3:    w = 32'd32;
			default: w = 32'h0000_0000;
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/sfci_front.sv =====
// ----------------------------------------------------------------------------
// SPIR-V float-controls injector front end
// Parses the incoming word stream, tracks the module state and issues one
// command per accepted word to the queue.
// ----------------------------------------------------------------------------
module sfci_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [31:0]       in_word,
	input  logic              in_last,
	input  logic              push,
	output sfci_pkg::cmd_t    cmd
);

	logic [2:0]  word_count_q, word_count_d;
	logic [15:0] words_left_q, words_left_d;
	logic [1:0]  word_index_q, word_index_d;
	logic        caps_q, caps_d;
	logic        modes_q, modes_d;
	logic        entry_seen_q, entry_seen_d;
	logic [31:0] ep_id_q, ep_id_d;
	logic        fault_q, fault_d;
	logic        in_entry_q, in_entry_d;
	logic        pend_q, pend_d;
	logic [31:0] pend_word_q, pend_word_d;
	logic [15:0] op;
	logic [15:0] len;

	assign op  = in_word[15:0];
	assign len = in_word[31:16];

	always_comb begin
		word_count_d = word_count_q;
		words_left_d = words_left_q;
		word_index_d = word_index_q;
		caps_d       = caps_q;
		modes_d      = modes_q;
		entry_seen_d = entry_seen_q;
		ep_id_d      = ep_id_q;
		fault_d      = fault_q;
		in_entry_d   = in_entry_q;
		pend_d       = 1'b0;
		pend_word_d  = pend_word_q;

		cmd.pend_v    = pend_q;
		cmd.pend_word = pend_word_q;
		cmd.ins       = sfci_pkg::INS_NONE;
		cmd.ep_id     = ep_id_q;
		cmd.word_v    = 1'b1;
		cmd.word      = in_word;
		cmd.last      = in_last;
		cmd.status    = sfci_pkg::STATUS_APPLIED;

		if (word_count_q < sfci_pkg::COUNT_SAT) begin
			word_count_d = word_count_q + 3'd1;
		end

		if (word_count_q >= sfci_pkg::HEADER_WORDS && !fault_q) begin
			if (words_left_q == 16'd0) begin
				if (len == 16'd0) begin
					fault_d = 1'b1;
				end else begin
					words_left_d = len - 16'd1;
					word_index_d = 2'd1;
					in_entry_d   = (op == sfci_pkg::OP_ENTRY_POINT);
					if (!caps_q && op != sfci_pkg::OP_CAPABILITY && !in_last && !pend_q) begin
						caps_d      = 1'b1;
						pend_d      = 1'b1;
						pend_word_d = in_word;
						cmd.ins     = sfci_pkg::INS_CAPS;
						cmd.word_v  = 1'b0;
					end else if (!modes_q && entry_seen_q && op != sfci_pkg::OP_ENTRY_POINT &&
							op != sfci_pkg::OP_EXECUTION_MODE) begin
						modes_d = 1'b1;
						cmd.ins = sfci_pkg::INS_MODES;
					end
				end
			end else begin
				if (word_index_q == 2'd2 && in_entry_q && !entry_seen_q) begin
					ep_id_d      = in_word;
					entry_seen_d = (in_word != 32'd0);
				end
				if (word_index_q != 2'd3) begin
					word_index_d = word_index_q + 2'd1;
				end
				words_left_d = words_left_q - 16'd1;
			end
		end

		if (in_last) begin
			if (word_count_q < sfci_pkg::HEADER_WORDS) begin
				cmd.status = sfci_pkg::STATUS_SHORT;
			end else if (fault_d || words_left_d != 16'd0) begin
				cmd.status = sfci_pkg::STATUS_MALFORMED;
			end else if (!(caps_d && modes_d)) begin
				cmd.status = sfci_pkg::STATUS_NO_POINT;
			end else begin
				cmd.status = sfci_pkg::STATUS_APPLIED;
			end
			word_count_d = 3'd0;
			words_left_d = 16'd0;
			word_index_d = 2'd0;
			caps_d       = 1'b0;
			modes_d      = 1'b0;
			entry_seen_d = 1'b0;
			ep_id_d      = 32'd0;
			fault_d      = 1'b0;
			in_entry_d   = 1'b0;
			pend_d       = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= '0;
			words_left_q <= '0;
			word_index_q <= '0;
			caps_q       <= 1'b0;
			modes_q      <= 1'b0;
			entry_seen_q <= 1'b0;
			ep_id_q      <= '0;
			fault_q      <= 1'b0;
			in_entry_q   <= 1'b0;
			pend_q       <= 1'b0;
		end else if (push) begin
			word_count_q <= word_count_d;
			words_left_q <= words_left_d;
			word_index_q <= word_index_d;
			caps_q       <= caps_d;
			modes_q      <= modes_d;
			entry_seen_q <= entry_seen_d;
			ep_id_q      <= ep_id_d;
			fault_q      <= fault_d;
			in_entry_q   <= in_entry_d;
			pend_q       <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pend_word_q <= pend_word_d;
		end
	end

endmodule

// ===== rtl/sfci_fifo.sv =====
// ----------------------------------------------------------------------------
// SPIR-V float-controls injector command queue
// A short first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module sfci_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sfci_pkg::cmd_t wr_cmd,
	output logic           ready,
	input  logic           pop,
	output logic           valid,
	output sfci_pkg::cmd_t rd_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	sfci_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign ready  = (count_q != FULL_CNT);
	assign valid  = (count_q != '0);
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

// ===== rtl/sfci_back.sv =====
// ----------------------------------------------------------------------------
// SPIR-V float-controls injector back end
// Expands each command into its run of output words and drives the output
// register.
// ----------------------------------------------------------------------------
module sfci_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  sfci_pkg::cmd_t cmd,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [31:0]    out_word,
	output logic           item_done,
	output logic           module_done,
	output logic [1:0]     status
);

	logic [3:0]  pos_q;
	logic [3:0]  base;
	logic [3:0]  n_ins;
	logic [3:0]  total;
	logic [3:0]  rel;
	logic        adv;
	logic        at_end;
	logic        is_word;
	logic [31:0] word_c;

	always_comb begin
		base = cmd.pend_v ? 4'd1 : 4'd0;
		case (cmd.ins)
			sfci_pkg::INS_CAPS:  n_ins = sfci_pkg::CAP_WORDS;
			sfci_pkg::INS_MODES: n_ins = sfci_pkg::MODE_WORDS;
			default:             n_ins = 4'd0;
		endcase
		total   = base + n_ins + (cmd.word_v ? 4'd1 : 4'd0);
		rel     = pos_q - base;
		at_end  = (pos_q == total - 4'd1);
		is_word = 1'b0;
		if (pos_q < base) begin
			word_c = cmd.pend_word;
		end else if (rel < n_ins) begin
			if (cmd.ins == sfci_pkg::INS_CAPS) begin
				word_c = sfci_pkg::cap_word(rel);
			end else begin
				word_c = sfci_pkg::mode_word(rel[2:0], cmd.ep_id);
			end
		end else begin
			word_c  = cmd.word;
			is_word = 1'b1;
		end
	end

	assign adv = cmd_valid && (!out_valid || out_ready);
	assign pop = adv && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (adv) begin
				pos_q     <= at_end ? 4'd0 : pos_q + 4'd1;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word    <= word_c;
			item_done   <= at_end;
			module_done <= is_word && cmd.last;
			status      <= (is_word && cmd.last) ? cmd.status : sfci_pkg::STATUS_APPLIED;
		end
	end

endmodule

// ===== rtl/spirv_float_controls_injector_core.sv =====
// ----------------------------------------------------------------------------
// SPIR-V float-controls injector
// Passes a SPIR-V module through word by word and inserts the float-controls
// capabilities, extension and execution modes.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Contents
// s_axis    in         tvalid/tready           tdata in_word, tlast in_last
// m_axis    out        tvalid/tready           tdata out_word, tlast module_done,
//                                              tuser item_done and status
//
// One input word is taken per cycle while the command queue has room.
// The back end sends one output word per cycle while m_axis is ready; an insertion of eight or
// eleven words fills the queue of DEPTH commands and then stalls the input.
// An input word passes through the queue memory, then the output register. Reset clears all control state.
module spirv_float_controls_injector_core #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] in_word
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] out_word
	output logic        m_axis_tlast,
	output logic [2:0]  m_axis_tuser    // [0] item_done, [2:1] status
);

	sfci_pkg::cmd_t wr_cmd;
	sfci_pkg::cmd_t rd_cmd;
	logic           push;
	logic           pop;
	logic           q_valid;
	logic           item_done;
	logic [1:0]     status;

	assign push         = s_axis_tvalid && s_axis_tready;
	assign m_axis_tuser = {status, item_done};

	sfci_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_word (s_axis_tdata),
		.in_last (s_axis_tlast),
		.push    (push),
		.cmd     (wr_cmd)
	);

	sfci_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.ready  (s_axis_tready),
		.pop    (pop),
		.valid  (q_valid),
		.rd_cmd (rd_cmd)
	);

	sfci_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (q_valid),
		.cmd         (rd_cmd),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_word    (m_axis_tdata),
		.item_done   (item_done),
		.module_done (m_axis_tlast),
		.status      (status)
	);

endmodule

// ===== rtl/sfci_checker.sv =====
// ----------------------------------------------------------------------------
// SPIR-V float-controls injector port checker
// Checks the output stream framing seen at the top-level ports.
// ----------------------------------------------------------------------------
module sfci_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [2:0]  m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
		$stable(m_axis_tlast))
		else $error("stalled output word changed");

	a_status_framed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[2:1] == sfci_pkg::STATUS_APPLIED)
		else $error("status set on a word that does not end the module");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
		else $error("module end without item end");

	a_idle_after_reset: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("output valid straight after reset");

endmodule

bind spirv_float_controls_injector_core sfci_checker u_sfci_checker (.*);

// ===== tb/sfci_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Float-controls injector stream checker
// Watches both stream channels. Every accepted input word is run through a
// behavioural rewrite of the module, and every output word is compared field
// by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module sfci_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	input  logic [2:0]  m_axis_tuser,
	output int          failures,
	output int          outstanding,
	output int          words_checked
);

	localparam logic [15:0] OP_EXTENSION    = 16'd10;
	localparam logic [31:0] CAP_DENORM_FTZ  = 32'd4465;
	localparam logic [31:0] CAP_SZ_INF_NAN  = 32'd4466;
	localparam logic [31:0] MODE_DENORM_FTZ = 32'd4460;
	localparam logic [31:0] MODE_SZ_INF_NAN = 32'd4461;
	localparam logic [31:0] FP_WIDTH        = 32'd32;
	localparam logic [31:0] CAP_HEADER      = {16'd2, sfci_pkg::OP_CAPABILITY};
	localparam logic [31:0] EXT_HEADER      = {16'd7, OP_EXTENSION};
	localparam logic [31:0] MODE_HEADER     = {16'd4, sfci_pkg::OP_EXECUTION_MODE};

	// The extension name string, four characters to a word, low byte first.
	localparam logic [31:0] INSERT_CAPS [0:10] = '{
		CAP_HEADER, CAP_DENORM_FTZ, CAP_HEADER, CAP_SZ_INF_NAN, EXT_HEADER,
		32'h5F56_5053, 32'h5F52_484B, 32'h616F_6C66, 32'h6F63_5F74,
		32'h6F72_746E, 32'h0000_736C
	};

	typedef struct packed {
		logic [31:0] word;
		logic        item_done;
		logic        module_done;
		logic [1:0]  status;
	} beat_t;

	beat_t rewritten_q[$];

	logic [2:0]  seen_words;
	logic [15:0] body_left;
	logic [1:0]  body_pos;
	logic        caps_added;
	logic        modes_added;
	logic        entry_found;
	logic [31:0] ep_id_r;
	logic        malformed;
	logic        in_entry;
	logic        held_v;
	logic [31:0] held_word;

	function automatic beat_t plain(input logic [31:0] w);
		return '{w, 1'b0, 1'b0, sfci_pkg::STATUS_APPLIED};
	endfunction

	task automatic reset_module();
		seen_words  = '0;
		body_left   = '0;
		body_pos    = '0;
		caps_added  = 1'b0;
		modes_added = 1'b0;
		entry_found = 1'b0;
		ep_id_r     = '0;
		malformed   = 1'b0;
		in_entry    = 1'b0;
		held_v      = 1'b0;
		held_word   = '0;
	endtask

	task automatic predict_rewrite(input logic [31:0] w, input logic is_last);
		beat_t       burst[$];
		logic [2:0]  prior;
		logic [15:0] op;
		logic [15:0] len;
		logic        held_now;
		int          k;
		int          tail;
		prior    = seen_words;
		held_now = 1'b0;
		if (seen_words < sfci_pkg::COUNT_SAT)
			seen_words = seen_words + 3'd1;
		if (held_v) begin
			burst.insert(burst.size(), plain(held_word));
			held_v = 1'b0;
		end
		if (prior >= sfci_pkg::HEADER_WORDS && !malformed) begin
			if (body_left == 16'd0) begin
				op  = w[15:0];
				len = w[31:16];
				if (len == 16'd0) begin
					malformed = 1'b1;
				end else begin
					body_left = len - 16'd1;
					body_pos  = 2'd1;
					in_entry  = (op == sfci_pkg::OP_ENTRY_POINT);
					if (!caps_added && op != sfci_pkg::OP_CAPABILITY && !is_last &&
							burst.size() == 0) begin
						for (k = 0; k < sfci_pkg::CAP_WORDS; k++)
							burst.insert(burst.size(), plain(INSERT_CAPS[k]));
						caps_added = 1'b1;
						held_v     = 1'b1;
						held_word  = w;
						held_now   = 1'b1;
					end else if (!modes_added && entry_found &&
							op != sfci_pkg::OP_ENTRY_POINT &&
							op != sfci_pkg::OP_EXECUTION_MODE) begin
						burst.insert(burst.size(), plain(MODE_HEADER));
						burst.insert(burst.size(), plain(ep_id_r));
						burst.insert(burst.size(), plain(MODE_DENORM_FTZ));
						burst.insert(burst.size(), plain(FP_WIDTH));
						burst.insert(burst.size(), plain(MODE_HEADER));
						burst.insert(burst.size(), plain(ep_id_r));
						burst.insert(burst.size(), plain(MODE_SZ_INF_NAN));
						burst.insert(burst.size(), plain(FP_WIDTH));
						modes_added = 1'b1;
					end
				end
			end else begin
				if (body_pos == 2'd2 && in_entry && !entry_found) begin
					ep_id_r     = w;
					entry_found = (w != 32'd0);
				end
				if (body_pos != 2'd3)
					body_pos = body_pos + 2'd1;
				body_left = body_left - 16'd1;
			end
		end
		if (!held_now)
			burst.insert(burst.size(), plain(w));
		tail = burst.size() - 1;
		burst[tail].item_done = 1'b1;
		if (is_last) begin
			burst[tail].module_done = 1'b1;
			if (prior < sfci_pkg::HEADER_WORDS)
				burst[tail].status = sfci_pkg::STATUS_SHORT;
			else if (malformed || body_left != 16'd0)
				burst[tail].status = sfci_pkg::STATUS_MALFORMED;
			else if (!(caps_added && modes_added))
				burst[tail].status = sfci_pkg::STATUS_NO_POINT;
			else
				burst[tail].status = sfci_pkg::STATUS_APPLIED;
			reset_module();
		end
		foreach (burst[i])
			rewritten_q.insert(rewritten_q.size(), burst[i]);
	endtask

	always @(posedge clk) begin : monitor
		beat_t got;
		beat_t want;
		if (!arst_n) begin
			reset_module();
			rewritten_q.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_rewrite(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[2:1]};
				words_checked++;
				if (rewritten_q.size() == 0) begin
					$error("Unexpected output word %h with nothing predicted", got.word);
					failures++;
				end else begin
					want = rewritten_q.pop_front();
					if (got.word !== want.word) begin
						$error("out_word: expected %h, actual %h", want.word, got.word);
						failures++;
					end
					if (got.item_done !== want.item_done) begin
						$error("item_done: expected %b, actual %b", want.item_done, got.item_done);
						failures++;
					end
					if (got.module_done !== want.module_done) begin
						$error("module_done: expected %b, actual %b", want.module_done,
							got.module_done);
						failures++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						failures++;
					end
				end
			end
		end
		outstanding = rewritten_q.size();
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Float-controls injector testbench
// Drives SPIR-V modules word by word into the injector: a few directed
// modules, then random well-formed modules with noise and broken ones mixed
// in, under random idling on both channels. The checker compares the output.
// ----------------------------------------------------------------------------
module tb;

	localparam int          RANDOM_WORDS    = 280;
	localparam int          CYCLE_LIMIT     = 200000;
	localparam int          IDLE_PCT        = 17;
	localparam int          DRAIN_CYCLES    = 20;
	localparam logic [15:0] OP_FUNCTION_END = 16'd56;
	localparam logic [31:0] SPIRV_MAGIC     = 32'h0723_0203;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [2:0]  m_axis_tuser;

	logic        steady;
	logic [32:0] stream_q[$];
	int          words_sent;
	int          modules_sent;
	int          cycle_count;
	int          random_base;
	int          failures;
	int          outstanding;
	int          words_checked;

	spirv_float_controls_injector_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	sfci_stream_checker rewrite_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.failures      (failures),
		.outstanding   (outstanding),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic push_word(input logic [31:0] w);
		stream_q.insert(stream_q.size(), {1'b0, w});
	endtask

	task automatic push_inst(input logic [15:0] op, input logic [15:0] len,
			input logic [31:0] id);
		int i;
		push_word({len, op});
		for (i = 1; i < len; i++)
			push_word((i == 2 && op == sfci_pkg::OP_ENTRY_POINT) ? id : $urandom);
	endtask

	task automatic end_module();
		stream_q[stream_q.size() - 1][32] = 1'b1;
	endtask

	// Mostly well-formed modules with random content; the rest are noise,
	// modules with a zero-length instruction, and modules cut short.
	task automatic build_module();
		int          start;
		int          kind;
		logic [31:0] id;
		logic [15:0] op;
		start = stream_q.size();
		kind  = $urandom_range(99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 12))
				push_word($urandom);
		end else begin
			push_word($urandom_range(1) ? SPIRV_MAGIC : $urandom);
			repeat (4)
				push_word($urandom);
			repeat ($urandom_range(0, 3))
				push_inst(sfci_pkg::OP_CAPABILITY, 16'd2, 32'd0);
			repeat ($urandom_range(0, 1))
				push_inst(16'($urandom_range(0, 400)), 16'($urandom_range(1, 5)), 32'd0);
			repeat ($urandom_range(0, 2)) begin
				id = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
				push_inst(sfci_pkg::OP_ENTRY_POINT,
					($urandom_range(4) == 0) ? 16'($urandom_range(1, 3)) :
					16'($urandom_range(4, 8)), id);
			end
			repeat ($urandom_range(0, 2))
				push_inst(sfci_pkg::OP_EXECUTION_MODE, 16'($urandom_range(3, 5)), 32'd0);
			repeat ($urandom_range(1, 4)) begin
				case ($urandom_range(5))
					0:       op = sfci_pkg::OP_CAPABILITY;
					1:       op = sfci_pkg::OP_ENTRY_POINT;
					2:       op = sfci_pkg::OP_EXECUTION_MODE;
					default: op = 16'($urandom);
				endcase
				push_inst(op, 16'($urandom_range(1, 5)), $urandom);
			end
			if (kind < 16) begin
				push_word({16'd0, 16'($urandom)});
				repeat ($urandom_range(0, 3))
					push_word($urandom);
			end else if (kind < 26 && stream_q.size() > start + 1) begin
				repeat ($urandom_range(1, stream_q.size() - start - 1))
					void'(stream_q.pop_back());
			end
		end
		end_module();
	endtask

	task automatic send_stream();
		logic [32:0] item;
		while (stream_q.size() > 0) begin
			item = stream_q.pop_front();
			@(negedge clk);
			while (!steady && $urandom_range(99) < IDLE_PCT) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= item[31:0];
			s_axis_tlast  <= item[32];
			do
				@(posedge clk);
			while (!s_axis_tready);
			words_sent++;
			if (item[32])
				modules_sent++;
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		steady        = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Too short: two words only, at both extremes.
		push_word(32'hFFFF_FFFF);
		push_word(32'h0000_0000);
		end_module();
		// Well-formed: a capability, entry point, then a plain instruction.
		push_word(SPIRV_MAGIC);
		repeat (4)
			push_word($urandom);
		push_inst(sfci_pkg::OP_CAPABILITY, 16'd2, 32'd0);
		push_inst(sfci_pkg::OP_ENTRY_POINT, 16'd4, 32'd5);
		push_word({16'd1, OP_FUNCTION_END});
		end_module();
		// A zero-length instruction makes the module malformed.
		push_word(SPIRV_MAGIC);
		repeat (4)
			push_word($urandom);
		push_word({16'd0, sfci_pkg::OP_CAPABILITY});
		push_word(32'hFFFF_FFFF);
		end_module();
		// The first non-capability instruction is the last word.
		push_word(SPIRV_MAGIC);
		repeat (4)
			push_word($urandom);
		push_word({16'd1, OP_FUNCTION_END});
		end_module();
		send_stream();
		drain_results();

		random_base = words_sent;
		while (words_sent - random_base < RANDOM_WORDS) begin
			steady = (words_sent - random_base >= 150 && words_sent - random_base < 230);
			build_module();
			send_stream();
			if ($urandom_range(9) == 0)
				drain_results();
		end
		steady = 1'b0;
		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Run summary: %0d words in %0d modules driven, %0d output words compared.",
			words_sent, modules_sent, words_checked);
		$display("Directed short, applied, zero-length and late-trigger modules came first.");
		if (failures == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sfci_pkg.sv
rtl/sfci_front.sv
rtl/sfci_fifo.sv
rtl/sfci_back.sv
rtl/spirv_float_controls_injector_core.sv
rtl/sfci_checker.sv
tb/sfci_stream_checker.sv
tb/tb.sv
